### sv/iidl_pkg.sv
// Shared types and constants for the indexed insert/delete list.
package iidl_pkg;

  localparam int DEPTH = 16;
  localparam int WIDTH = 32;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_READ   = 2'd2,
    MODE_NONE   = 2'd3
  } iidl_mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_NONE  = 2'd3
  } iidl_status_t;

  // Broadcast to every cell for one request.
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [IDX_W-1:0] pos;
  } iidl_op_t;

endpackage

### sv/iidl_cell.sv
// One list slot: holds an entry and shifts it with its neighbors.
module iidl_cell (
  input  logic                      clk,
  input  iidl_pkg::iidl_op_t        op,
  input  logic [iidl_pkg::IDX_W-1:0] cell_index,
  input  logic [iidl_pkg::WIDTH-1:0] new_value,
  input  logic [iidl_pkg::WIDTH-1:0] left_q,
  input  logic [iidl_pkg::WIDTH-1:0] right_q,
  output logic [iidl_pkg::WIDTH-1:0] q
);
  import iidl_pkg::*;

  always_ff @(posedge clk) begin
    if (op.ins) begin
      if (cell_index == op.pos) begin
        q <= new_value;
      end else if (cell_index > op.pos) begin
        q <= left_q;
      end
    end else if (op.del && (cell_index >= op.pos)) begin
      q <= right_q;
    end
  end

endmodule

### sv/indexed_insert_delete_list_top.sv
// Indexed insert/delete list top: a row of shifting cells plus count and result register.
// The result is registered on accept and is valid in the cycle after it.
// One request per cycle unless a result is stalled; all cells shift in parallel on accept.
// Reset clears the count and the result valid; entries are not cleared.
module indexed_insert_delete_list_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [4:0]  position,
  input  logic [31:0] item_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result_value,
  output logic [1:0]  status,
  output logic [4:0]  entry_count
);
  import iidl_pkg::*;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             accept;
  logic [31:0]      pos_ext;
  logic [31:0]      cnt_ext;
  logic [IDX_W-1:0] pos_idx;
  logic [WIDTH-1:0] store_value;
  logic [WIDTH-1:0] rd_value;
  logic [31:0]      result_next;
  iidl_status_t     status_next;
  iidl_op_t         op;
  logic [WIDTH-1:0] cell_q [DEPTH];

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign pos_ext  = 32'(position);
  assign cnt_ext  = 32'(count);
  assign pos_idx  = IDX_W'(position);
  assign store_value = WIDTH'(item_value);
  assign rd_value = cell_q[pos_idx];

  always_comb begin
    status_next = ST_OK;
    result_next = '0;
    count_next  = count;
    op.ins      = 1'b0;
    op.del      = 1'b0;
    op.pos      = pos_idx;
    unique case (iidl_mode_t'(mode))
      MODE_INSERT: begin
        if (pos_ext > cnt_ext) begin
          status_next = ST_RANGE;
        end else if (cnt_ext >= 32'(DEPTH)) begin
          status_next = ST_FULL;
        end else begin
          op.ins     = accept;
          count_next = count + CNT_W'(1);
        end
      end
      MODE_DELETE: begin
        if (pos_ext >= cnt_ext) begin
          status_next = ST_RANGE;
        end else begin
          op.del      = accept;
          result_next = 32'(rd_value);
          count_next  = count - CNT_W'(1);
        end
      end
      MODE_READ: begin
        if (pos_ext >= cnt_ext) begin
          status_next = ST_RANGE;
        end else begin
          result_next = 32'(rd_value);
        end
      end
      default: begin
        status_next = ST_RANGE;
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] left_q;
    logic [WIDTH-1:0] right_q;
    if (i == 0) begin : g_head
      assign left_q = '0;
    end else begin : g_body
      assign left_q = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_q = '0;
    end else begin : g_link
      assign right_q = cell_q[i+1];
    end
    iidl_cell u_cell (
      .clk        (clk),
      .op         (op),
      .cell_index (IDX_W'(i)),
      .new_value  (store_value),
      .left_q     (left_q),
      .right_q    (right_q),
      .q          (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_value <= result_next;
      status       <= status_next;
      entry_count  <= 5'(count_next);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= 32'(DEPTH))
    else $error("count above capacity");

  a_accept_valid: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("no result after accepted request");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (result_value == '0))
    else $error("error result carries a value");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> (32'(entry_count) == 32'(DEPTH)))
    else $error("full status with list not full");
`endif

endmodule
